// ----- rtl/core/dtsi_pkg.sv -----
// Package: shared types, codes and helpers of the decimal text to integer block
`timescale 1ns / 1ps
`default_nettype none

package dtsi_pkg;

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_PARSE = 2'd1;
    localparam logic [1:0] STAT_OVF   = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MAG      = 2'd1;

    // field widths
    localparam int unsigned EXP_W   = 9;
    localparam int unsigned SCALE_W = 9;

    localparam logic signed [EXP_W-1:0]   EXP_FLOOR  = -9'sd255;
    localparam logic signed [SCALE_W-1:0] SCALE_CEIL = 9'sd255;

    // decoded character
    typedef struct packed {
        logic       is_digit;
        logic       is_point;
        logic       is_minus;
        logic       is_plus;
        logic [3:0] digit;
    } char_class_t;

    function automatic logic signed [SCALE_W-1:0] scale_inc(
        input logic signed [SCALE_W-1:0] s
    );
        scale_inc = (s < SCALE_CEIL) ? s + 9'sd1 : s;
    endfunction

    function automatic logic signed [EXP_W-1:0] exp_dec(
        input logic signed [EXP_W-1:0] e
    );
        exp_dec = (e > EXP_FLOOR) ? e - 9'sd1 : e;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dtsi_if.sv -----
// Interfaces: character, result and configuration channels
`timescale 1ns / 1ps
`default_nettype none

interface dtsi_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;
    logic       is_empty;

    modport source (output valid, char_code, is_last, is_empty, input ready);
    modport sink   (input valid, char_code, is_last, is_empty, output ready);
endinterface

interface dtsi_res_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic              sign_neg;
    logic              is_nonempty;
    logic signed [8:0] exponent;
    logic [63:0]       magnitude;

    modport source (output valid, status, sign_neg, is_nonempty, exponent, magnitude,
                    input ready);
    modport sink   (input valid, status, sign_neg, is_nonempty, exponent, magnitude,
                    output ready);
endinterface

interface dtsi_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/decimal_text_to_scaled_integer.sv -----
// Top level: decimal text to scaled integer parser with padding sequencer
//
//  channel | dir | payload                                          | accepted when
//  --------+-----+--------------------------------------------------+----------------------
//  chars   | in  | char_code[7:0], is_last, is_empty                | valid && ready
//  result  | out | status[1:0], sign_neg, is_nonempty, exponent[8:0], magnitude[63:0]
//                                                                     | valid && ready
//  cfg     | in  | index[1:0], data[63:0]                           | valid && ready
//
//  One character word is taken per cycle in RUN while chars.ready is high; the shared x10+digit unit
//  folds it into the accumulator in that same cycle.
//  After the last word, each padding step (up to 32, i.e. -target_scale minus
//  fraction digits) runs a zero through the same unit, then the result word is
//  loaded into the output register.
//  chars.ready is low while padding and while a finished result waits with
//  result.ready low. cfg.ready is always high.
//  Reset (async, rst_n low) clears all number state and loads the register
//  defaults: target_scale 0, max_magnitude 2^63-1.
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_scaled_integer #(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input wire logic clk,
    input wire logic rst_n,
    dtsi_char_if.sink   chars,
    dtsi_res_if.source  result,
    dtsi_cfg_if.sink    cfg
);

    localparam int unsigned SW = dtsi_pkg::SCALE_W;
    localparam int unsigned EW = dtsi_pkg::EXP_W;

    // largest value the accumulator can hold
    localparam logic [64:0] CAP65 = (65'd1 << VALUE_WIDTH) - 65'd1;
    localparam logic [63:0] CAP   = CAP65[63:0];

    // sequencer codes
    localparam logic ST_RUN = 1'b0;
    localparam logic ST_PAD = 1'b1;

    // ---------------- configuration registers ----------------
    logic signed [5:0] target_scale_reg, target_scale_next;
    logic [62:0]       max_mag_reg, max_mag_next;
    logic              cfg_fire;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    always_comb
    begin
        target_scale_next = target_scale_reg;
        max_mag_next      = max_mag_reg;
        if (cfg_fire)
        begin
            unique case (cfg.index)
                dtsi_pkg::CFG_TARGET_SCALE: target_scale_next = cfg.data[5:0];
                dtsi_pkg::CFG_MAX_MAG:      max_mag_next      = cfg.data[62:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // ---------------- number state ----------------
    logic                   state_reg, state_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   first_reg, first_next;
    logic                   neg_reg, neg_next;
    logic                   point_reg, point_next;
    logic signed [SW-1:0]   scale_reg, scale_next;
    logic signed [EW-1:0]   exp_reg, exp_next;
    logic [1:0]             err_reg, err_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_status_reg, out_status_next;
    logic                   out_neg_reg, out_neg_next;
    logic                   out_nonempty_reg, out_nonempty_next;
    logic signed [EW-1:0]   out_exp_reg, out_exp_next;
    logic [63:0]            out_mag_reg, out_mag_next;

    logic signed [SW-1:0]   target_ext;
    logic                   in_fire;
    logic                   out_fire;

    assign target_ext = {{(SW-6){target_scale_reg[5]}}, target_scale_reg};
    assign out_fire   = out_valid_reg && result.ready;
    // the output slot is free, or frees at this edge
    assign chars.ready = (state_reg == ST_RUN) && (!out_valid_reg || result.ready);
    assign in_fire     = chars.valid && chars.ready;

    // ---------------- character decode ----------------
    dtsi_pkg::char_class_t cls;

    dtsi_classify u_classify (
        .char_code (chars.char_code),
        .cls       (cls)
    );

    // ---------------- shared x10 unit ----------------
    logic                   unit_neg;
    logic [3:0]             unit_digit;
    logic [63:0]            lim64;
    logic [63:0]            lim_eff;
    logic [VALUE_WIDTH-1:0] unit_result;
    logic                   unit_ovf;

    // limit: max_magnitude, one more when negative, never above the width cap
    assign lim64   = {1'b0, max_mag_reg} + {63'd0, unit_neg};
    assign lim_eff = (lim64 > CAP) ? CAP : lim64;

    dtsi_mac10 #(
        .WIDTH (VALUE_WIDTH)
    ) u_mac10 (
        .acc    (acc_reg),
        .digit  (unit_digit),
        .limit  (lim_eff[VALUE_WIDTH-1:0]),
        .result (unit_result),
        .ovf    (unit_ovf)
    );

    // ---------------- sequencer ----------------
    logic take;
    logic sign_char;
    logic produce;
    logic done_clear;

    always_comb
    begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        first_next    = first_reg;
        neg_next      = neg_reg;
        point_next    = point_reg;
        scale_next    = scale_reg;
        exp_next      = exp_reg;
        err_next      = err_reg;

        unit_neg      = neg_reg;
        unit_digit    = 4'd0;
        take          = 1'b0;
        sign_char     = 1'b0;
        produce       = 1'b0;
        done_clear    = 1'b0;

        out_status_next   = out_status_reg;
        out_neg_next      = out_neg_reg;
        out_nonempty_next = out_nonempty_reg;
        out_exp_next      = out_exp_reg;
        out_mag_next      = out_mag_reg;

        unique case (state_reg)
            ST_RUN:
            begin
                take      = in_fire && !chars.is_empty && (err_reg == dtsi_pkg::STAT_OK);
                sign_char = first_reg && (cls.is_minus || cls.is_plus);
                unit_neg  = neg_reg || (first_reg && cls.is_minus);
                unit_digit = cls.digit;

                if (take)
                begin
                    if (first_reg)
                    begin
                        first_next = 1'b0;
                        scale_next = target_ext;
                        neg_next   = cls.is_minus;
                    end
                    if (!sign_char)
                    begin
                        if (cls.is_digit)
                        begin
                            if (unit_ovf)
                                err_next = dtsi_pkg::STAT_OVF;
                            else
                            begin
                                acc_next = unit_result;
                                if (point_reg)
                                begin
                                    scale_next = dtsi_pkg::scale_inc(
                                        first_reg ? target_ext : scale_reg);
                                    exp_next   = dtsi_pkg::exp_dec(exp_reg);
                                end
                            end
                        end
                        else if (cls.is_point)
                        begin
                            if (point_reg)
                                err_next = dtsi_pkg::STAT_PARSE;
                            else
                                point_next = 1'b1;
                        end
                        else
                            err_next = dtsi_pkg::STAT_PARSE;
                    end
                end

                if (in_fire && chars.is_last)
                begin
                    if (first_next)
                    begin
                        // empty string: all-zero OK result
                        produce           = 1'b1;
                        done_clear        = 1'b1;
                        out_status_next   = dtsi_pkg::STAT_OK;
                        out_neg_next      = 1'b0;
                        out_nonempty_next = 1'b0;
                        out_exp_next      = '0;
                        out_mag_next      = '0;
                    end
                    else if ((err_next == dtsi_pkg::STAT_OK) && (scale_next < 0))
                        state_next = ST_PAD;
                    else
                    begin
                        produce           = 1'b1;
                        done_clear        = 1'b1;
                        out_status_next   = err_next;
                        out_neg_next      = neg_next;
                        out_nonempty_next = 1'b1;
                        out_exp_next      = (err_next == dtsi_pkg::STAT_OK) ? exp_next : '0;
                        out_mag_next      = (err_next == dtsi_pkg::STAT_OK) ?
                                            64'(acc_next) : '0;
                    end
                end
            end

            ST_PAD:
            begin
                // one padding zero per cycle
                unit_neg   = neg_reg;
                unit_digit = 4'd0;
                if (unit_ovf)
                begin
                    produce           = 1'b1;
                    done_clear        = 1'b1;
                    state_next        = ST_RUN;
                    out_status_next   = dtsi_pkg::STAT_OVF;
                    out_neg_next      = neg_reg;
                    out_nonempty_next = 1'b1;
                    out_exp_next      = '0;
                    out_mag_next      = '0;
                end
                else
                begin
                    acc_next   = unit_result;
                    scale_next = scale_reg + 9'sd1;
                    exp_next   = dtsi_pkg::exp_dec(exp_reg);
                    if (scale_reg == -9'sd1)
                    begin
                        produce           = 1'b1;
                        done_clear        = 1'b1;
                        state_next        = ST_RUN;
                        out_status_next   = dtsi_pkg::STAT_OK;
                        out_neg_next      = neg_reg;
                        out_nonempty_next = 1'b1;
                        out_exp_next      = exp_next;
                        out_mag_next      = 64'(unit_result);
                    end
                end
            end

            default: state_next = ST_RUN;
        endcase

        if (done_clear)
        begin
            acc_next   = '0;
            first_next = 1'b1;
            neg_next   = 1'b0;
            point_next = 1'b0;
            scale_next = target_ext;
            exp_next   = '0;
            err_next   = dtsi_pkg::STAT_OK;
        end

        if (produce)
            out_valid_next = 1'b1;
        else if (out_fire)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_scale_reg <= '0;
            max_mag_reg      <= '1;
            state_reg        <= ST_RUN;
            acc_reg          <= '0;
            first_reg        <= 1'b1;
            neg_reg          <= 1'b0;
            point_reg        <= 1'b0;
            scale_reg        <= '0;
            exp_reg          <= '0;
            err_reg          <= dtsi_pkg::STAT_OK;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            target_scale_reg <= target_scale_next;
            max_mag_reg      <= max_mag_next;
            state_reg        <= state_next;
            acc_reg          <= acc_next;
            first_reg        <= first_next;
            neg_reg          <= neg_next;
            point_reg        <= point_next;
            scale_reg        <= scale_next;
            exp_reg          <= exp_next;
            err_reg          <= err_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_status_reg   <= out_status_next;
        out_neg_reg      <= out_neg_next;
        out_nonempty_reg <= out_nonempty_next;
        out_exp_reg      <= out_exp_next;
        out_mag_reg      <= out_mag_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = out_status_reg;
    assign result.sign_neg    = out_neg_reg;
    assign result.is_nonempty = out_nonempty_reg;
    assign result.exponent    = out_exp_reg;
    assign result.magnitude   = out_mag_reg;

endmodule

`default_nettype wire

// ----- rtl/core/dtsi_classify.sv -----
// Character decoder: sorts one ASCII code into digit, point, sign or other
`timescale 1ns / 1ps
`default_nettype none

module dtsi_classify (
    input  wire logic [7:0]           char_code,
    output dtsi_pkg::char_class_t     cls
);

    logic [7:0] offset;

    always_comb
    begin
        offset       = char_code - dtsi_pkg::CH_ZERO;
        cls.is_digit = (char_code >= dtsi_pkg::CH_ZERO) && (char_code <= dtsi_pkg::CH_NINE);
        cls.is_point = (char_code == dtsi_pkg::CH_POINT);
        cls.is_minus = (char_code == dtsi_pkg::CH_MINUS);
        cls.is_plus  = (char_code == dtsi_pkg::CH_PLUS);
        cls.digit    = offset[3:0];
    end

endmodule

`default_nettype wire

// ----- rtl/core/dtsi_mac10.sv -----
// Shared unit: acc * 10 + digit with overflow check against a limit
`timescale 1ns / 1ps
`default_nettype none

module dtsi_mac10 #(
    parameter int unsigned WIDTH = 64
) (
    input  wire logic [WIDTH-1:0] acc,
    input  wire logic [3:0]       digit,
    input  wire logic [WIDTH-1:0] limit,
    output logic      [WIDTH-1:0] result,
    output logic                  ovf
);

    logic [WIDTH+3:0] acc_ext;
    logic [WIDTH+3:0] sum;

    always_comb
    begin
        acc_ext = {4'b0000, acc};
        // x*10 = x*8 + x*2
        sum     = (acc_ext << 3) + (acc_ext << 1) + {{WIDTH{1'b0}}, digit};
        ovf     = sum > {4'b0000, limit};
        result  = sum[WIDTH-1:0];
    end

endmodule

`default_nettype wire
